FILE: rtl/assert_macros.svh
// Assertion helpers; every check is clocked on clk and muted during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PLE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define PLE_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/ple_pkg.sv
`default_nettype none
package ple_pkg;

	localparam int DATA_W      = 32;
	localparam int IDX_W       = 6;   // covers every legal depth up to 64
	localparam int MAX_RESULTS = 32;

	typedef enum logic [2:0] {
		ACT_INS_FRONT = 3'd0,
		ACT_INS_BACK  = 3'd1,
		ACT_INS_AT    = 3'd2,
		ACT_DEL_FRONT = 3'd3,
		ACT_DEL_BACK  = 3'd4,
		ACT_DEL_AT    = 3'd5,
		ACT_DUMP      = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_BADPOS = 2'd1,
		STS_FULL   = 2'd2,
		STS_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RESP,
		S_DUMP
	} state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL,
		CELL_ROT
	} cell_kind_t;

	// Broadcast command to every cell of the chain.
	typedef struct packed {
		cell_kind_t               kind;
		logic [IDX_W-1:0]         idx;       // insert / delete slot
		logic [IDX_W-1:0]         last_idx;  // top occupied slot, for rotate
		logic signed [DATA_W-1:0] value;
	} cell_op_t;

	typedef struct packed {
		logic [2:0]               action;
		logic [5:0]               position;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic [5:0]               count;
		logic signed [DATA_W-1:0] element;
		logic                     last;
	} rsp_t;

endpackage
`default_nettype wire

FILE: rtl/ple_stream_if.sv
`default_nettype none
interface ple_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/ple_cell.sv
`default_nettype none
module ple_cell import ple_pkg::*; #(
	parameter logic [IDX_W-1:0] INDEX = '0
) (
	input  logic                     clk,
	input  cell_op_t                 op,
	input  logic signed [DATA_W-1:0] from_lo,  // neighbor at INDEX-1
	input  logic signed [DATA_W-1:0] from_hi,  // neighbor at INDEX+1
	input  logic signed [DATA_W-1:0] head,     // slot 0, wraps on rotate
	output logic signed [DATA_W-1:0] data
);

	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (op.kind)
			CELL_INS: begin
				if (INDEX == op.idx) begin
					data_d = op.value;
				end else if (INDEX > op.idx) begin
					data_d = from_lo;
				end
			end
			CELL_DEL: begin
				if (INDEX >= op.idx) begin
					data_d = from_hi;
				end
			end
			CELL_ROT: begin
				if (INDEX < op.last_idx) begin
					data_d = from_hi;
				end else if (INDEX == op.last_idx) begin
					data_d = head;
				end
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule
`default_nettype wire

FILE: rtl/positional_list_engine_core.sv
// Insert, delete or rejected request: the result is presented in the cycle after accept.
// A non-dump request is accepted, then its result handed off; no new request is taken before that.
// Dump of n elements: n rotation steps, results (at most MAX_RESULTS) one per cycle at full
//   output rate, then the next request; an empty dump returns one STS_EMPTY result.
// Reset: arst_n clears the count and control; element cells keep no reset.
`default_nettype none
module positional_list_engine_core import ple_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	ple_stream_if.sink    req,
	ple_stream_if.source  rsp
);

	`include "assert_macros.svh"

	// Count holds 0..DEPTH; compares run one bit wider than either operand.
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = ((CW > 6) ? CW : 6) + 1;

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	state_t          state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [CW-1:0]   k_q, k_d;        // dump rotation step
	status_t         status_q, status_d;

	cell_op_t        op;

	// Element chain: slot 0 is the list head.
	logic signed [DATA_W-1:0] cell_data [DEPTH];

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic signed [DATA_W-1:0] lo_in, hi_in;
			if (gi == 0) begin : g_lo_edge
				assign lo_in = '0;
			end else begin : g_lo
				assign lo_in = cell_data[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_hi_edge
				assign hi_in = '0;
			end else begin : g_hi
				assign hi_in = cell_data[gi+1];
			end
			ple_cell #(.INDEX(IDX_W'(gi))) u_cell (
				.clk     (clk),
				.op      (op),
				.from_lo (lo_in),
				.from_hi (hi_in),
				.head    (cell_data[0]),
				.data    (cell_data[gi])
			);
		end
	endgenerate

	// ------------------------------------------------------------------
	// Widened views for position checks
	// ------------------------------------------------------------------
	logic [CMPW-1:0] pos_x, cnt_x, cnt_m1_x, k_x, nemit_x;
	logic            is_empty, is_full, ins_badpos, del_badpos;
	logic [CW+5:0]   count_ext;

	assign pos_x      = CMPW'(req.data.position);
	assign cnt_x      = CMPW'(count_q);
	assign cnt_m1_x   = cnt_x - CMPW'(1);
	assign k_x        = CMPW'(k_q);
	assign nemit_x    = (cnt_x > CMPW'(MAX_RESULTS)) ? CMPW'(MAX_RESULTS) : cnt_x;
	assign is_empty   = (count_q == '0);
	assign is_full    = (cnt_x >= CMPW'(DEPTH));
	assign ins_badpos = (pos_x == '0) || (pos_x > cnt_x + CMPW'(1));
	assign del_badpos = (pos_x == '0) || (pos_x > cnt_x);
	// count field is the low six bits of the element count
	assign count_ext  = {6'b0, count_q};

	// Set for an insert request that will succeed; used by checks below.
	logic ins_ok;

	// ------------------------------------------------------------------
	// Sequencer: decode, drive the chain, present results
	// ------------------------------------------------------------------
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		k_d         = k_q;
		status_d    = status_q;
		ins_ok      = 1'b0;
		op.kind     = CELL_HOLD;
		op.idx      = '0;
		op.last_idx = cnt_m1_x[IDX_W-1:0];
		op.value    = req.data.value;

		req.ready        = 1'b0;
		rsp.valid        = 1'b0;
		rsp.data.status  = status_q;
		rsp.data.count   = count_ext[5:0];
		rsp.data.element = '0;
		rsp.data.last    = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = S_RESP;
					unique case (req.data.action) inside
						ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
							if (req.data.action == ACT_INS_AT && ins_badpos) begin
								status_d = STS_BADPOS;
							end else if (is_full) begin
								status_d = STS_FULL;
							end else begin
								status_d = STS_OK;
								ins_ok   = 1'b1;
								op.kind  = CELL_INS;
								count_d  = count_q + CW'(1);
								if (req.data.action == ACT_INS_FRONT) begin
									op.idx = '0;
								end else if (req.data.action == ACT_INS_BACK) begin
									op.idx = cnt_x[IDX_W-1:0];
								end else begin
									op.idx = pos_x[IDX_W-1:0] - IDX_W'(1);
								end
							end
						end
						ACT_DEL_FRONT, ACT_DEL_BACK: begin
							if (is_empty) begin
								status_d = STS_EMPTY;
							end else begin
								status_d = STS_OK;
								op.kind  = CELL_DEL;
								count_d  = count_q - CW'(1);
								op.idx   = (req.data.action == ACT_DEL_FRONT) ?
									'0 : cnt_m1_x[IDX_W-1:0];
							end
						end
						ACT_DEL_AT: begin
							if (del_badpos) begin
								status_d = STS_BADPOS;
							end else begin
								status_d = STS_OK;
								op.kind  = CELL_DEL;
								count_d  = count_q - CW'(1);
								op.idx   = pos_x[IDX_W-1:0] - IDX_W'(1);
							end
						end
						ACT_DUMP: begin
							if (is_empty) begin
								status_d = STS_EMPTY;
							end else begin
								status_d = STS_OK;
								k_d      = '0;
								state_d  = S_DUMP;
							end
						end
						default: status_d = STS_BADPOS;  // unused action code
					endcase
				end
			end
			S_RESP: begin
				rsp.valid = 1'b1;
				if (rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			S_DUMP: begin
				// Head slot is shown, then the used part of the chain rotates by
				// one. After count steps the list is back in its original order;
				// steps past the result limit rotate without showing anything.
				rsp.valid        = (k_x < nemit_x);
				rsp.data.status  = STS_OK;
				rsp.data.element = cell_data[0];
				rsp.data.last    = (k_x + CMPW'(1) == nemit_x);
				if (!rsp.valid || rsp.ready) begin
					op.kind = CELL_ROT;
					k_d     = k_q + CW'(1);
					if (k_x == cnt_m1_x) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			k_q      <= '0;
			status_q <= STS_OK;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			k_q      <= k_d;
			status_q <= status_d;
		end
	end

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`PLE_NEVER(a_no_overlap, req.ready && rsp.valid, "request taken while result pending")
	`PLE_NEVER(a_count_bound, cnt_x > CMPW'(DEPTH), "element count beyond depth")
	`PLE_ASSERT(a_ins_grows, (req.valid && req.ready && ins_ok) |=> (count_q == $past(count_q) + CW'(1)), "insert did not grow count")
	`PLE_ASSERT(a_dump_stable, (state_q == S_DUMP) |-> $stable(count_q), "count moved during dump")

endmodule
`default_nettype wire
